@@ hdl/i4dq_pkg.sv @@
// ----------------------------------------------------------------------------
// i4dq_pkg: shared constants and functions for the int4 dequantiser
// Holds the nibble mask and the binary16 widening and nibble scaling helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package i4dq_pkg;

  localparam logic [3:0]  NibbleMask = 4'hF;
  localparam logic [31:0] DefaultNan = 32'h7FC0_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;

  // Leading one position of a nonzero 14-bit magnitude.
  function automatic logic [3:0] msb_pos(input logic [13:0] v);
    logic [3:0] p;
    p = 4'd0;
    for (int i = 0; i < 14; i++) begin
      if (v[i]) p = 4'(i);
    end
    return p;
  endfunction

  // Binary32 bits of (-1)^s * mag * 2^(ex), ex given as biased offset ebase = ex + 127.
  function automatic logic [31:0] make_normal(input logic s, input logic [13:0] mag,
                                              input logic [8:0] ebase);
    logic [3:0]  m;
    logic [36:0] sh;
    logic [8:0]  be;
    m  = msb_pos(mag);
    sh = {23'd0, mag} << (5'd23 - {1'b0, m});
    be = ebase + {5'd0, m};
    return {s, be[7:0], sh[22:0]};
  endfunction

  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [4:0] e;
    logic [9:0] f;
    e = h[14:10];
    f = h[9:0];
    if (e == 5'h1F) return {h[15], 8'hFF, f, 13'd0};
    if (e == 5'd0) begin
      if (f == 10'd0) return {h[15], 31'd0};
      return make_normal(h[15], {4'd0, f}, 9'd103);
    end
    return make_normal(h[15], {3'd0, 1'b1, f}, 9'd102 + {4'd0, e});
  endfunction

endpackage

`default_nettype wire

@@ hdl/int4_fp16_scale_dequant_unit.sv @@
// ----------------------------------------------------------------------------
// int4_fp16_scale_dequant_unit: int4 weight times fp16 scale to fp32
// Input channel: one beat per weight element (packed byte, nibble select,
// fp16 group scale, outlier flag and fp16 outlier value). Output channel:
// one beat per element with the IEEE binary32 bits of the weight.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. The input is registered, the nibble is multiplied by the scale
// mantissa (4 x 11 bits) and normalised, and the result lands in the output
// register. Throughput is one beat per cycle; the only limit is the
// two-register pipeline, which keeps flowing while the output is taken.
// When the receiver stalls, the output register holds its beat and the
// input register holds too once full; in_stall_o then rises.
// Reset clears both valid flags; no beat is pending afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module int4_fp16_scale_dequant_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  packed_byte_i,
  input  wire logic        odd_column_i,
  input  wire logic [15:0] scale_bits_i,
  input  wire logic        is_outlier_i,
  input  wire logic [15:0] outlier_bits_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      weight_bits_o
);

  logic        s1_valid_q;
  logic [3:0]  nib_q, nib_d;
  logic [15:0] scale_q;
  logic        outl_q;
  logic [15:0] oval_q;
  logic        adv2, adv1;
  logic [31:0] res_d, res_q;

  logic        qneg, sign;
  logic [3:0]  qmag;
  logic [4:0]  e;
  logic [9:0]  f;
  logic [10:0] m;
  logic [13:0] p;
  logic [8:0]  ebase;

  assign adv2       = !(out_valid_o && out_stall_i);
  assign adv1       = adv2 || !s1_valid_q;
  assign in_stall_o = !adv1;
  assign nib_d      = odd_column_i ? (packed_byte_i[7:4] & i4dq_pkg::NibbleMask)
                                   : (packed_byte_i[3:0] & i4dq_pkg::NibbleMask);

  always_comb begin
    qneg  = nib_q[3];
    qmag  = qneg ? (4'd0 - nib_q) : nib_q;
    sign  = scale_q[15] ^ qneg;
    e     = scale_q[14:10];
    f     = scale_q[9:0];
    m     = (e == 5'd0) ? {1'b0, f} : {1'b1, f};
    ebase = (e == 5'd0) ? 9'd103 : 9'd102 + {4'd0, e};
    p     = {10'd0, qmag} * {3'd0, m};
    if (outl_q) begin
      res_d = i4dq_pkg::widen_half(oval_q);
    end else if (e == 5'h1F) begin
      if (f != 10'd0)         res_d = i4dq_pkg::widen_half(scale_q) | i4dq_pkg::QuietBit;
      else if (nib_q == 4'd0) res_d = i4dq_pkg::DefaultNan;
      else                    res_d = {sign, 8'hFF, 23'd0};
    end else if (p == 14'd0) begin
      res_d = {sign, 31'd0};
    end else begin
      res_d = i4dq_pkg::make_normal(sign, p, ebase);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (adv1) s1_valid_q <= in_valid_i;
      if (adv2) out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      nib_q   <= nib_d;
      scale_q <= scale_bits_i;
      outl_q  <= is_outlier_i;
      oval_q  <= outlier_bits_i;
    end
    if (adv2 && s1_valid_q) res_q <= res_d;
  end

  assign weight_bits_o = res_q;

endmodule

`default_nettype wire
